### src/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants for the sorted priority queue
// Holds the queue depth, derived widths, operation and status codes, and
// the entry and cell control types used by the cell row and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W      = 16;
    localparam int TAG_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED_LAST = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]         tag;
    } entry_t;

    // Broadcast to every cell in the cycle an item is accepted.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage : mpq_pkg

`default_nettype wire

### src/max_priority_queue_core.sv
// ----------------------------------------------------------------------------
// max_priority_queue_core: bounded sorted priority queue, highest first
// A row of cells holds the entries in sorted order, head in cell 0. Each
// operation is resolved by all cells in parallel, at the edge that accepts it.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------------------
//  input    in_valid / in_stall  operation, priority_req, tag
//  output   out_valid/out_stall  status, out_priority, out_tag, occupancy
//
// The cell row and the output register both load at the edge that accepts
// an item, so its result is shown in the output register in the next cycle.
// The rate is one item per cycle while results are taken, since the compare
// and shift across the cell row finish at that edge. A new item is accepted while a result waits
// only if that result is taken in the same cycle; otherwise in_stall is high.
// Reset empties the queue and the output register; cell contents are left
// as they are, since only cells below the entry count are ever read.
//
`default_nettype none

module max_priority_queue_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire                                  operation,
    input  wire signed [mpq_pkg::PRIO_W-1:0]     priority_req,
    input  wire        [mpq_pkg::TAG_W-1:0]      tag,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic       [mpq_pkg::STATUS_W-1:0]   status,
    output logic signed [mpq_pkg::PRIO_W-1:0]    out_priority,
    output logic       [mpq_pkg::TAG_W-1:0]      out_tag,
    output logic       [mpq_pkg::OCC_W-1:0]      occupancy
);
    import mpq_pkg::*;

    // Number of held entries; cells below this index are occupied.
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // Output register. Valid is control state; the payload needs no reset.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    entry_t              result_reg;
    entry_t              result_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    cell_ctrl_t          ctrl;

    entry_t              cell_entry [QUEUE_DEPTH];
    logic                cell_ge    [QUEUE_DEPTH];
    logic                cell_occ   [QUEUE_DEPTH];

    // The output register frees up when its result is taken this cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Only legal operations move the cell row: a full queue rejects an insert
    // and an empty queue ignores a remove.
    always_comb
    begin
        ctrl.insert         = accept && (operation == OP_ENQUEUE) && !is_full;
        ctrl.remove         = accept && (operation == OP_DEQUEUE) && !is_empty;
        ctrl.new_entry.prio = priority_req;
        ctrl.new_entry.tag  = tag;
    end

    // Cell 0 sees an imaginary left neighbor that always stays ahead, so it
    // takes the new entry unless it keeps its own. The last cell feeds back
    // its own entry on a remove; that slot becomes unoccupied anyway.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_ge;
        entry_t right_entry;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_entry = ctrl.new_entry;
            assign left_ge    = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_ge    = cell_ge[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        mpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (cell_occ[i]),
            .left_entry  (left_entry),
            .left_ge     (left_ge),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i])
        );
    end

    // Result formation and entry count update.
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        result_next    = result_reg;
        occ_next       = occ_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            result_next    = '0;
            if (operation == OP_ENQUEUE)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ENQUEUED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    result_next = cell_entry[0];
                    status_next = (count_reg == CNT_W'(1)) ? ST_REMOVED_LAST : ST_REMOVED;
                end
            end
            occ_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        occ_reg    <= occ_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_priority = result_reg.prio;
    assign out_tag      = result_reg.tag;
    assign occupancy    = occ_reg;

endmodule : max_priority_queue_core

`default_nettype wire

### src/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell: one slot of the sorted shift-register queue
// Holds one entry and, on each operation, keeps it, takes the new entry, or
// takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cell (
    input  wire                       clk,
    input  wire mpq_pkg::cell_ctrl_t  ctrl,
    input  wire                       occupied,
    input  wire mpq_pkg::entry_t      left_entry,
    input  wire                       left_ge,
    input  wire mpq_pkg::entry_t      right_entry,
    output mpq_pkg::entry_t           entry,
    output logic                      ge
);
    import mpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // This slot holds an entry that stays ahead of the one being inserted.
    assign ge    = occupied && (entry_reg.prio >= ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (ge)
                entry_next = entry_reg;
            else if (left_ge)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : mpq_cell

`default_nettype wire

### test/max_priority_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue_core_test: self-checking bench for the sorted queue
// Drives enqueue and dequeue items with random gaps and output stalls.
// A shadow copy of the sorted store predicts each result, and every result
// the block returns is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module max_priority_queue_core_test;

    import mpq_pkg::*;

    localparam int TOTAL_ITEMS    = 850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;

    // One queue operation as the driver offers it. The drain flag makes the
    // driver hold the item back until every earlier result has come back.
    typedef struct {
        logic   op;
        entry_t entry;
        bit     drain_first;
    } queue_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        entry_t              entry;
        logic [OCC_W-1:0]    occupancy;
    } queue_result_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       operation = OP_ENQUEUE;
    logic signed [PRIO_W-1:0]   priority_req = '0;
    logic [TAG_W-1:0]           tag = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b1;
    logic [STATUS_W-1:0]        status;
    logic signed [PRIO_W-1:0]   out_priority;
    logic [TAG_W-1:0]           out_tag;
    logic [OCC_W-1:0]           occupancy;

    queue_op_t     op_backlog[$];
    queue_result_t predicted_results[$];

    // Shadow of the sorted store, head in entry 0.
    entry_t shadow_entries[QUEUE_DEPTH];
    int     shadow_count;

    int fail_count;
    int enqueue_count;
    int dequeue_count;
    int full_reject_count;
    int empty_dequeue_count;
    int peak_occupancy;
    int results_seen;
    int idle_cycles;

    max_priority_queue_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .priority_req (priority_req),
        .tag          (tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_tag      (out_tag),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Length of an idle stretch: mostly short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Priorities lean on the extremes and on a narrow band so that ties,
    // and with them the first-in first-out rule, come up often.
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        else if (r < 55)
            return PRIO_W'($signed($urandom_range(0, 8)) - 4);
        else
            return PRIO_W'($urandom);
    endfunction

    task automatic add_op(input logic op, input logic signed [PRIO_W-1:0] prio,
                          input logic [TAG_W-1:0] payload, input bit drain_first);
        queue_op_t item;
        item.op          = op;
        item.entry.prio  = prio;
        item.entry.tag   = payload;
        item.drain_first = drain_first;
        op_backlog.push_back(item);
    endtask

    // Applies one accepted item to the shadow store and queues the result
    // the block is expected to return for it.
    task automatic apply_to_shadow_queue(input queue_op_t item);
        queue_result_t res;
        int            pos;
        int            i;
        res.status    = ST_ENQUEUED;
        res.entry     = '0;
        if (item.op == OP_ENQUEUE)
        begin
            enqueue_count++;
            if (shadow_count >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
                full_reject_count++;
            end
            else
            begin
                // The new entry goes behind every entry of equal or higher
                // priority.
                pos = 0;
                while (pos < shadow_count &&
                       $signed(shadow_entries[pos].prio) >= $signed(item.entry.prio))
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i - 1];
                shadow_entries[pos] = item.entry;
                shadow_count++;
            end
        end
        else
        begin
            dequeue_count++;
            if (shadow_count == 0)
            begin
                res.status = ST_EMPTY;
                empty_dequeue_count++;
            end
            else
            begin
                res.entry = shadow_entries[0];
                for (i = 1; i < shadow_count; i++)
                    shadow_entries[i - 1] = shadow_entries[i];
                shadow_count--;
                res.status = (shadow_count == 0) ? ST_REMOVED_LAST : ST_REMOVED;
            end
        end
        res.occupancy = OCC_W'(shadow_count);
        if (shadow_count > peak_occupancy)
            peak_occupancy = shadow_count;
        predicted_results.push_back(res);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver. The payload is set only when a new item is first offered, so it
    // holds steady for as long as the block stalls the input.
    // ------------------------------------------------------------------------
    int ops_accepted;
    int send_gap;
    int send_calm;

    always @(posedge clk or negedge rst_n)
    begin
        logic offer_now;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            operation    <= OP_ENQUEUE;
            priority_req <= '0;
            tag          <= '0;
            ops_accepted = 0;
            send_gap     = 0;
            send_calm    = 0;
        end
        else
        begin
            offer_now = in_valid;
            if (in_valid && !in_stall)
            begin
                apply_to_shadow_queue(op_backlog.pop_front());
                ops_accepted++;
                offer_now = 1'b0;
                // Pick the gap before the next item. Calm stretches send
                // back to back.
                if (send_calm > 0)
                begin
                    send_calm--;
                    send_gap = 0;
                end
                else if ($urandom_range(0, 149) == 0)
                begin
                    send_calm = $urandom_range(20, 60);
                    send_gap  = 0;
                end
                else
                    send_gap = ($urandom_range(0, 99) < 55) ? 0 : idle_length();
            end
            if (!offer_now)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (op_backlog.size() > 0 &&
                         (!op_backlog[0].drain_first || ops_accepted == results_seen))
                begin
                    // A drain item waits until every result so far is back.
                    offer_now    = 1'b1;
                    operation    <= op_backlog[0].op;
                    priority_req <= op_backlog[0].entry.prio;
                    tag          <= op_backlog[0].entry.tag;
                end
            end
            in_valid <= offer_now;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Checks each taken result against the oldest prediction and
    // decides the stall for the next cycle. Twice in the run it holds the
    // output off for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------------
    int hold_left;
    int stall_left;
    int take_calm;

    always @(posedge clk or negedge rst_n)
    begin
        logic          stall_now;
        queue_result_t want;
        if (!rst_n)
        begin
            out_stall    <= 1'b1;
            results_seen <= 0;
            hold_left    = 0;
            stall_left   = 0;
            take_calm    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, status %0d prio %0d tag %0d occ %0d",
                             $time, status, out_priority, out_tag, occupancy);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("out_priority", $signed(want.entry.prio), $signed(out_priority));
                    check_field("out_tag", want.entry.tag, out_tag);
                    check_field("occupancy", want.occupancy, occupancy);
                end
                if (results_seen == 40 || results_seen == 500)
                    hold_left = 80;
                results_seen <= results_seen + 1;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_now = 1'b1;
            end
            else if (take_calm > 0)
            begin
                take_calm--;
                stall_now = 1'b0;
            end
            else if ($urandom_range(0, 99) < 70)
            begin
                stall_now = 1'b0;
                if ($urandom_range(0, 99) == 0)
                    take_calm = $urandom_range(20, 80);
            end
            else
            begin
                stall_now  = 1'b1;
                stall_left = idle_length() - 1;
            end
            out_stall <= stall_now;
        end
    end

    // The watchdog ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int  k;
        int  phase_len;
        int  enqueue_pct;
        bit  drain_done;
        bit  drain_now;

        fail_count          = 0;
        enqueue_count       = 0;
        dequeue_count       = 0;
        full_reject_count   = 0;
        empty_dequeue_count = 0;
        peak_occupancy      = 0;
        shadow_count        = 0;
        idle_cycles         = 0;
        drain_done          = 1'b0;

        // Dequeue from an empty queue, then the priority extremes and a tie
        // on zero, which must come out in arrival order. The last of the
        // four dequeues after them takes the last entry.
        add_op(OP_DEQUEUE, 16'sh0000, 8'h00, 1'b0);
        add_op(OP_ENQUEUE, 16'sh7fff, 8'hff, 1'b0);
        add_op(OP_ENQUEUE, 16'sh8000, 8'h00, 1'b0);
        add_op(OP_ENQUEUE, 16'sh0000, 8'haa, 1'b0);
        add_op(OP_ENQUEUE, 16'sh0000, 8'h55, 1'b0);
        for (k = 0; k < 4; k++)
            add_op(OP_DEQUEUE, 16'shffff, 8'hff, 1'b0);
        // Fill the queue with a mix of ties and spread values, then try one
        // more insert, which must be rejected.
        for (k = 0; k < QUEUE_DEPTH; k++)
            add_op(OP_ENQUEUE, (k % 3 == 0) ? 16'shffff : PRIO_W'(k * 4001 - 30000),
                   TAG_W'(k * 17), 1'b0);
        add_op(OP_ENQUEUE, 16'sh7fff, 8'hff, 1'b0);

        // Random phases alternate between filling, balanced and draining
        // mixes so the queue swings between empty and full many times.
        while (op_backlog.size() < TOTAL_ITEMS)
        begin
            phase_len = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0: enqueue_pct = 80;
                1: enqueue_pct = 50;
                default: enqueue_pct = 20;
            endcase
            drain_now = !drain_done && op_backlog.size() >= 400;
            if (drain_now)
                drain_done = 1'b1;
            for (k = 0; k < phase_len && op_backlog.size() < TOTAL_ITEMS; k++)
                add_op(($urandom_range(0, 99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                       pick_priority(), TAG_W'($urandom), drain_now && k == 0);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d enqueues (%0d rejected as full) and %0d dequeues (%0d on empty).",
                 enqueue_count, full_reject_count, dequeue_count, empty_dequeue_count);
        $display("Peak occupancy %0d of %0d, %0d results checked, %0d mismatches.",
                 peak_occupancy, QUEUE_DEPTH, results_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
src/mpq_pkg.sv
src/mpq_cell.sv
src/max_priority_queue_core.sv
test/max_priority_queue_core_test.sv
